/* rtl/b64e_pkg.sv */
// Shared types, constants and the character mapping of the Base64 stream encoder.
package b64e_pkg;

   // Pad character appended to short final groups.
   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // Number of characters one item can produce at most.
   localparam int MAX_CHARS = 4;
   localparam int CIDX_W    = $clog2(MAX_CHARS);

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One classified item: its characters, the index of its last one, and
   // whether it ends the message.
   typedef struct packed {
      logic [MAX_CHARS-1:0][7:0] chars;
      logic [CIDX_W-1:0]         last_idx;
      logic                      final_flag;
   } job_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

   // Map a sextet onto the standard Base64 alphabet.
   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] ch;
      priority if (v < 6'd26) begin
         ch = {2'b00, v} + 8'd65;
      end else if (v < 6'd52) begin
         ch = {2'b00, v} + 8'd71;
      end else if (v < 6'd62) begin
         ch = {2'b00, v} - 8'd4;
      end else if (v == 6'd62) begin
         ch = 8'h2B;
      end else begin
         ch = 8'h2F;
      end
      return ch;
   endfunction

endpackage

/* rtl/base64_stream_encoder_top.sv */
// Top level of the streaming Base64 encoder with its checks.
//
// Usage:
//   The req_ channel takes one raw message byte per item, with
//   req_final_byte set on the last byte of a message. The rsp_ channel
//   delivers one ASCII character per item from the standard alphabet,
//   '=' padding included, with rsp_final_char set on the message's last one.
//   The first character of a byte passes through the job queue and then
//   the output register. The back end sends one character per cycle while
//   rsp_stall does not hold the output, and a byte yields one to four
//   characters; a steady stream carries four characters per three bytes,
//   its pace set by the single-character output register.
//   A two-entry job queue sits between the front, which classifies bytes,
//   and the back, which serializes characters; req_stall rises only when
//   that queue is full.
//   Reset (synchronous, active high) returns the encoder to the start of
//   a group and empties the queue and the output register.
//   While rsp_stall is high the current character holds; bytes are still
//   accepted until the queue fills.
module base64_stream_encoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_final_char
);

   logic                       push;
   logic                       pop;
   b64e_pkg::job_type          push_job;
   b64e_pkg::job_type          head_job;
   b64e_pkg::q_status_type     q_status;

   assign req_stall = q_status.full;

   // Front end: byte classification.
   b64e_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .push_ready     (!q_status.full),
      .push           (push),
      .push_job       (push_job)
   );

   // Job queue.
   b64e_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   // Back end: character output.
   b64e_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (q_status.not_empty),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_char   (rsp_out_char),
      .rsp_final_char (rsp_final_char)
   );

   // The queue never takes a job while full.
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !push)
      else $error("job pushed into a full queue");

   // The back end never retires a job from an empty queue.
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_status.not_empty)
      else $error("job popped from an empty queue");

   // A new character only appears when a job was waiting.
   a_rsp_from_job: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(q_status.not_empty))
      else $error("character produced without a queued job");

endmodule

/* rtl/b64e_front.sv */
// Front end: accepts bytes, tracks the group position and builds character jobs.
module b64e_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [7:0]          req_data_byte,
   input  logic                req_final_byte,
   input  logic                push_ready,
   output logic                push,
   output b64e_pkg::job_type   push_job
);

   typedef enum logic [1:0] {
      PH_START  = 2'd0,
      PH_SECOND = 2'd1,
      PH_THIRD  = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] left_ff, left_in;

   assign push = req_valid && push_ready;

   // Classify the byte by its position within the three-byte group.
   always_comb begin
      phase_in          = phase_ff;
      left_in           = left_ff;
      push_job.chars    = {b64e_pkg::MAX_CHARS{b64e_pkg::PAD_CHAR}};
      push_job.last_idx = '0;
      push_job.final_flag = req_final_byte;
      unique case (phase_ff)
         PH_SECOND: begin
            push_job.chars[0] = b64e_pkg::sextet_char({left_ff[1:0], req_data_byte[7:4]});
            if (req_final_byte) begin
               push_job.chars[1] = b64e_pkg::sextet_char({req_data_byte[3:0], 2'b00});
               push_job.last_idx = b64e_pkg::CIDX_W'(2);
               phase_in          = PH_START;
               left_in           = 4'd0;
            end else begin
               phase_in = PH_THIRD;
               left_in  = req_data_byte[3:0];
            end
         end
         PH_THIRD: begin
            push_job.chars[0] = b64e_pkg::sextet_char({left_ff, req_data_byte[7:6]});
            push_job.chars[1] = b64e_pkg::sextet_char(req_data_byte[5:0]);
            push_job.last_idx = b64e_pkg::CIDX_W'(1);
            phase_in          = PH_START;
            left_in           = 4'd0;
         end
         default: begin
            // Start of group; the unused phase code behaves the same.
            push_job.chars[0] = b64e_pkg::sextet_char(req_data_byte[7:2]);
            if (req_final_byte) begin
               push_job.chars[1] = b64e_pkg::sextet_char({req_data_byte[1:0], 4'b0000});
               push_job.last_idx = b64e_pkg::CIDX_W'(3);
               phase_in          = PH_START;
               left_in           = 4'd0;
            end else begin
               phase_in = PH_SECOND;
               left_in  = {2'b00, req_data_byte[1:0]};
            end
         end
      endcase
   end

   // Group position and leftover bits advance only on an accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         left_ff  <= 4'd0;
      end else if (push) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule

/* rtl/b64e_queue.sv */
// Short register queue of character jobs between the front and the back.
module b64e_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  b64e_pkg::job_type        push_job,
   input  logic                     pop,
   output b64e_pkg::job_type        head_job,
   output b64e_pkg::q_status_type   status
);

   b64e_pkg::job_type                 mem_ff [b64e_pkg::QUEUE_DEPTH];
   logic [b64e_pkg::QPTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [b64e_pkg::QCNT_W-1:0]       count_ff;

   assign status.full      = (count_ff == b64e_pkg::QCNT_W'(b64e_pkg::QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign head_job         = mem_ff[rd_ptr_ff];

   // Advance a pointer with wrap at the queue depth.
   function automatic logic [b64e_pkg::QPTR_W-1:0] next_ptr(
      input logic [b64e_pkg::QPTR_W-1:0] p);
      logic [b64e_pkg::QPTR_W-1:0] n;
      if (p == b64e_pkg::QPTR_W'(b64e_pkg::QUEUE_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + 1'b1;
      end
      return n;
   endfunction

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

/* rtl/b64e_back.sv */
// Back end: sends the characters of the head job one item per cycle unless rsp_stall holds the output.
module b64e_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  b64e_pkg::job_type   head_job,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_char,
   output logic                rsp_final_char
);

   logic                        valid_ff;
   logic [7:0]                  char_ff;
   logic                        final_ff;
   logic [b64e_pkg::CIDX_W-1:0] idx_ff;
   logic                        load;
   logic                        last;

   // The output register takes a new character when empty or being taken.
   assign load = head_valid && (!valid_ff || !rsp_stall);
   assign last = (idx_ff == head_job.last_idx);
   assign pop  = load && last;

   assign rsp_valid      = valid_ff;
   assign rsp_out_char   = char_ff;
   assign rsp_final_char = final_ff;

   // Output register and character index within the head job.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= last ? '0 : idx_ff + 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         char_ff  <= head_job.chars[idx_ff];
         final_ff <= last && head_job.final_flag;
      end
   end

endmodule

/* sim/base64_encoder_checker.sv */
// Checker for the Base64 stream encoder: predicts each character and compares it on the output.
module base64_encoder_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_char,
   input  logic       rsp_final_char,
   output int         fail_count,
   output int         expected_count,
   output int         chars_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   // Position of the next byte within its three-byte group.
   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_THIRD  = 2'd2
   } group_pos_type;

   // One predicted character and its end-of-message flag.
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } enc_char_type;

   localparam logic [8*64-1:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   enc_char_type  pending_chars[$];
   group_pos_type group_pos = PH_FIRST;
   logic [3:0]    carry_bits = 4'd0;

   // The string literal is packed with its first letter in the top byte.
   function automatic logic [7:0] alphabet_char(input logic [5:0] v);
      return ALPHABET[8*(63 - int'(v)) +: 8];
   endfunction

   function void push_char(input logic [7:0] ch, input logic last);
      enc_char_type e;
      e.ch   = ch;
      e.last = last;
      pending_chars.push_back(e);
   endfunction

   // Advance the predicted encoder by one byte and queue the characters it completes.
   task encode_byte(input logic [7:0] b, input logic fin);
      case (group_pos)
         PH_SECOND: begin
            push_char(alphabet_char({carry_bits[1:0], b[7:4]}), 1'b0);
            if (fin) begin
               push_char(alphabet_char({b[3:0], 2'b00}), 1'b0);
               push_char(b64e_pkg::PAD_CHAR, 1'b1);
               group_pos  = PH_FIRST;
               carry_bits = 4'd0;
            end else begin
               carry_bits = b[3:0];
               group_pos  = PH_THIRD;
            end
         end
         PH_THIRD: begin
            push_char(alphabet_char({carry_bits, b[7:6]}), 1'b0);
            push_char(alphabet_char(b[5:0]), fin);
            group_pos  = PH_FIRST;
            carry_bits = 4'd0;
         end
         // The unused phase value behaves like the start of a group.
         default: begin
            push_char(alphabet_char(b[7:2]), 1'b0);
            if (fin) begin
               push_char(alphabet_char({b[1:0], 4'b0000}), 1'b0);
               push_char(b64e_pkg::PAD_CHAR, 1'b0);
               push_char(b64e_pkg::PAD_CHAR, 1'b1);
               group_pos  = PH_FIRST;
               carry_bits = 4'd0;
            end else begin
               carry_bits = {2'b00, b[1:0]};
               group_pos  = PH_SECOND;
            end
         end
      endcase
   endtask

   // Compare accepted characters first, then predict from an accepted byte.
   always @(posedge clock) begin : monitor
      enc_char_type want;
      int           errs;
      errs = 0;
      if (reset) begin
         group_pos  = PH_FIRST;
         carry_bits = 4'd0;
         pending_chars.delete();
         fail_count    <= 0;
         chars_checked <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_chars.size() == 0) begin
               $error("unexpected character: out_char %h final_char %b",
                      rsp_out_char, rsp_final_char);
               errs++;
            end else begin
               want = pending_chars.pop_front();
               if (rsp_out_char !== want.ch) begin
                  $error("out_char: expected %h, got %h", want.ch, rsp_out_char);
                  errs++;
               end
               if (rsp_final_char !== want.last) begin
                  $error("final_char: expected %b, got %b", want.last, rsp_final_char);
                  errs++;
               end
            end
            chars_checked <= chars_checked + 1;
         end
         if (req_valid && !req_stall) begin
            encode_byte(req_data_byte, req_final_byte);
         end
         fail_count <= fail_count + errs;
      end
      expected_count <= pending_chars.size();
   end

endmodule

/* sim/testbench.sv */
// Top of the Base64 encoder testbench: clock, reset, byte stimulus, output stalls and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic FIN = 1'b1;
   localparam logic MID = 1'b0;
   localparam int   DIRECTED_COUNT = 24;
   localparam int   RANDOM_BYTES   = 296;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte  = 8'h00;
   logic       req_final_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_final_char;

   int fail_count;
   int expected_count;
   int chars_checked;
   int bytes_sent    = 0;
   int messages_sent = 0;
   bit steady        = 1'b0;

   logic [8:0] directed_bytes [DIRECTED_COUNT];

   always #5 clock = ~clock;

   base64_stream_encoder_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_char   (rsp_out_char),
      .rsp_final_char (rsp_final_char)
   );

   base64_encoder_checker encode_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_char   (rsp_out_char),
      .rsp_final_char (rsp_final_char),
      .fail_count     (fail_count),
      .expected_count (expected_count),
      .chars_checked  (chars_checked)
   );

   // Idle cycles before the next item; none during a steady stretch.
   function automatic int draw_wait();
      return steady ? 0 : int'($urandom_range(0, 7));
   endfunction

   // Offer one byte and hold it until the encoder takes it.
   task send_byte(input logic [7:0] b, input logic fin);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_final_byte <= fin;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // Send a message of random bytes, with the extremes mixed in now and then.
   task send_message(input int len);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end else begin
            b = 8'($urandom);
         end
         send_byte(b, (i == len - 1) ? FIN : MID);
      end
      messages_sent++;
   endtask

   // Output side: stall for a random number of cycles before each character.
   initial begin : receiver
      int hold;
      forever begin
         hold = draw_wait();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Overall limit, far beyond the slowest correct run.
   initial begin : watchdog
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      int len;
      int drain;
      // Short messages ending at every group position, the extreme bytes,
      // the two last alphabet letters, and back-to-back messages.
      directed_bytes = '{
         {FIN, 8'h00},
         {FIN, 8'hFF},
         {MID, 8'h00}, {FIN, 8'hFF},
         {MID, 8'hFF}, {FIN, 8'h00},
         {MID, 8'h00}, {MID, 8'h00}, {FIN, 8'h00},
         {MID, 8'hFF}, {MID, 8'hFF}, {FIN, 8'hFF},
         {MID, 8'hFB}, {MID, 8'hFF}, {FIN, 8'hBF},
         {MID, 8'h4D}, {MID, 8'h61}, {MID, 8'h6E}, {FIN, 8'h00},
         {MID, 8'h4D}, {MID, 8'h61}, {MID, 8'h6E}, {MID, 8'hFF}, {FIN, 8'h80}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
         if (directed_bytes[i][8]) messages_sent++;
      end

      // Random messages, mostly short, a few long, some without idle cycles.
      while (bytes_sent < DIRECTED_COUNT + RANDOM_BYTES) begin
         steady = ($urandom_range(0, 5) == 0);
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
         send_message(len);
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      // Wait for the last characters, then a few more cycles for strays.
      drain = 0;
      do begin
         @(posedge clock);
         drain++;
      end while (expected_count != 0 && drain < 5000);
      repeat (8) @(posedge clock);
      if (expected_count != 0) begin
         $error("%0d expected characters never arrived", expected_count);
      end

      $display("Encoded %0d bytes in %0d messages and checked %0d characters,",
               bytes_sent, messages_sent, chars_checked);
      $display("with random gaps and stalls on both channels and some steady stretches.");
      if (fail_count == 0 && expected_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
